// File: rtl/core/pdf_pkg.sv
// Shared types and constants for the packet deframer with CRC-32 check.
package pdf_pkg;

    localparam int HEADER_BYTES = 22;
    localparam int COUNT_W      = 17;

    typedef logic [COUNT_W-1:0] count_t;

    localparam count_t HDR_LEN   = count_t'(HEADER_BYTES);
    localparam count_t COUNT_MAX = '1;
    localparam count_t OFS_TYPE  = count_t'(2);
    localparam count_t OFS_CONN  = count_t'(3);
    localparam count_t OFS_SEQ   = count_t'(7);
    localparam count_t OFS_ACK   = count_t'(11);
    localparam count_t OFS_LEN   = count_t'(15);
    localparam count_t OFS_SUM   = count_t'(17);
    localparam count_t OFS_PAD   = count_t'(21);

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ONES = 32'hFFFF_FFFF;

    localparam logic CFG_MAGIC   = 1'b0;
    localparam logic CFG_MAX_LEN = 1'b1;

    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_VERDICT = 1'b1;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_BAD_MAGIC = 3'd2,
        ST_TOO_LONG  = 3'd3,
        ST_TRUNCATED = 3'd4,
        ST_CRC_BAD   = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [7:0]  payload_byte;
        status_t     status;
        logic [7:0]  pkt_type;
        logic [31:0] conn_id;
        logic [31:0] seq_num;
        logic [31:0] ack_num;
        logic [15:0] payload_len;
        logic [31:0] rx_checksum;
        logic [7:0]  pad_byte;
        logic        end_of_run;
    } out_item_t;

    typedef struct packed {
        logic      a_valid;
        logic      b_valid;
        out_item_t a;
        out_item_t b;
    } push_t;

endpackage

// File: rtl/core/pdf_parse.sv
// Header capture, CRC-32 update and verdict generation for one received byte.
module pdf_parse
    import pdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata,
    input  logic        take,
    input  in_item_t    in_data,
    output push_t       push
);

    function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    logic [15:0] magic_value_reg;
    logic [15:0] len_limit_reg;

    count_t      count_reg, count_next;
    logic [31:0] crc_reg, crc_next;
    logic [15:0] magic_reg, magic_next;
    logic [7:0]  type_reg, type_next;
    logic [31:0] conn_reg, conn_next;
    logic [31:0] seq_reg, seq_next;
    logic [31:0] ack_reg, ack_next;
    logic [15:0] len_reg, len_next;
    logic [31:0] sum_reg, sum_next;
    logic [7:0]  pad_reg, pad_next;

    logic        pay;
    logic        crc_en;
    logic [7:0]  crc_in;
    count_t      p;
    logic [7:0]  b;
    status_t     status;
    out_item_t   pay_item;
    out_item_t   ver_item;

    always_comb
    begin
        p          = count_reg;
        b          = in_data.data_byte;
        magic_next = magic_reg;
        type_next  = type_reg;
        conn_next  = conn_reg;
        seq_next   = seq_reg;
        ack_next   = ack_reg;
        len_next   = len_reg;
        sum_next   = sum_reg;
        pad_next   = pad_reg;
        pay        = 1'b0;
        crc_en     = 1'b0;
        crc_in     = b;

        if (p < HDR_LEN)
        begin
            crc_en = 1'b1;
            if (p < OFS_TYPE)
                magic_next = {magic_reg[7:0], b};
            else if (p == OFS_TYPE)
                type_next = b;
            else if (p < OFS_SEQ)
                conn_next = {conn_reg[23:0], b};
            else if (p < OFS_ACK)
                seq_next = {seq_reg[23:0], b};
            else if (p < OFS_LEN)
                ack_next = {ack_reg[23:0], b};
            else if (p < OFS_SUM)
                len_next = {len_reg[7:0], b};
            else if (p < OFS_PAD)
                sum_next = {sum_reg[23:0], b};
            else
                pad_next = b;
            if (p >= OFS_SUM && p < OFS_PAD)
                crc_in = 8'd0;
        end
        else if (p < HDR_LEN + {1'b0, len_reg})
        begin
            crc_en = 1'b1;
            pay    = 1'b1;
        end

        crc_next   = crc_en ? crc_step(crc_reg, crc_in) : crc_reg;
        count_next = (count_reg == COUNT_MAX) ? count_reg : count_reg + count_t'(1);

        if (count_next < HDR_LEN)
            status = ST_SHORT;
        else if (magic_next != magic_value_reg)
            status = ST_BAD_MAGIC;
        else if (len_next > len_limit_reg)
            status = ST_TOO_LONG;
        else if (count_next < HDR_LEN + {1'b0, len_next})
            status = ST_TRUNCATED;
        else if ((crc_next ^ CRC_ONES) != sum_next)
            status = ST_CRC_BAD;
        else
            status = ST_OK;

        pay_item              = '0;
        pay_item.kind         = KIND_PAYLOAD;
        pay_item.payload_byte = b;
        pay_item.status       = ST_OK;
        pay_item.end_of_run   = !in_data.last;

        ver_item              = '0;
        ver_item.kind         = KIND_VERDICT;
        ver_item.status       = status;
        ver_item.pkt_type     = type_next;
        ver_item.conn_id      = conn_next;
        ver_item.seq_num      = seq_next;
        ver_item.ack_num      = ack_next;
        ver_item.payload_len  = len_next;
        ver_item.rx_checksum  = sum_next;
        ver_item.pad_byte     = pad_next;
        ver_item.end_of_run   = 1'b1;

        if (pay)
        begin
            push.a_valid = take;
            push.a       = pay_item;
            push.b_valid = take && in_data.last;
            push.b       = ver_item;
        end
        else
        begin
            push.a_valid = take && in_data.last;
            push.a       = ver_item;
            push.b_valid = 1'b0;
            push.b       = ver_item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_value_reg <= '0;
            len_limit_reg   <= '1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_MAGIC:   magic_value_reg <= cfg_wdata;
                CFG_MAX_LEN: len_limit_reg   <= cfg_wdata;
                default:     magic_value_reg <= magic_value_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            crc_reg   <= CRC_ONES;
            magic_reg <= '0;
            type_reg  <= '0;
            conn_reg  <= '0;
            seq_reg   <= '0;
            ack_reg   <= '0;
            len_reg   <= '0;
            sum_reg   <= '0;
            pad_reg   <= '0;
        end
        else if (take)
        begin
            if (in_data.last)
            begin
                count_reg <= '0;
                crc_reg   <= CRC_ONES;
                magic_reg <= '0;
                type_reg  <= '0;
                conn_reg  <= '0;
                seq_reg   <= '0;
                ack_reg   <= '0;
                len_reg   <= '0;
                sum_reg   <= '0;
                pad_reg   <= '0;
            end
            else
            begin
                count_reg <= count_next;
                crc_reg   <= crc_next;
                magic_reg <= magic_next;
                type_reg  <= type_next;
                conn_reg  <= conn_next;
                seq_reg   <= seq_next;
                ack_reg   <= ack_next;
                len_reg   <= len_next;
                sum_reg   <= sum_next;
                pad_reg   <= pad_next;
            end
        end
    end

`ifndef ASSERT_OFF
    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        take && in_data.last |=> count_reg == '0 && crc_reg == CRC_ONES)
        else $error("State not cleared after the final byte of a buffer.");

    a_payload_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        push.a_valid && push.a.kind == KIND_PAYLOAD |-> count_reg >= HDR_LEN)
        else $error("Payload item emitted from inside the header.");
`endif

endmodule

// File: rtl/core/pdf_queue.sv
// Four-entry result queue that takes up to two items per cycle and issues one per cycle while out_ready is high.
module pdf_queue
    import pdf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  push_t     push,
    output logic      room,
    output logic      out_valid,
    input  logic      out_ready,
    output out_item_t out_data
);

    out_item_t   mem [4];
    logic [1:0]  wr_ptr_reg, wr_ptr_next;
    logic [1:0]  rd_ptr_reg, rd_ptr_next;
    logic [2:0]  count_reg, count_next;
    logic        pop;
    logic [2:0]  n_push;

    always_comb
    begin
        pop         = out_valid && out_ready;
        n_push      = {2'd0, push.a_valid} + {2'd0, push.b_valid};
        wr_ptr_next = wr_ptr_reg + n_push[1:0];
        rd_ptr_next = rd_ptr_reg + {1'b0, pop};
        count_next  = count_reg + n_push - {2'd0, pop};
    end

    assign room      = count_reg <= 3'd2;
    assign out_valid = count_reg != 3'd0;
    assign out_data  = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push.a_valid)
            mem[wr_ptr_reg] <= push.a;
        if (push.b_valid)
            mem[wr_ptr_reg + 2'd1] <= push.b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_second_needs_first: assert property (@(posedge clk) disable iff (!rst_n)
        push.b_valid |-> push.a_valid)
        else $error("Second queue write without a first.");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.a_valid |-> count_reg <= 3'd2)
        else $error("Result queue written without room for two items.");
`endif

endmodule

// File: rtl/core/packet_deframer_crc32_check_unit.sv
// Top level of the packet deframer with reflected CRC-32 check.
// The input channel (in_valid, in_ready, in_data) takes one byte of a received
// buffer per item; in_data.last marks the final byte. The output channel
// (out_valid, out_ready, out_data) issues result items: a provisional payload
// item for each byte within the declared length, and a verdict item with the
// status and the header fields on the final byte. end_of_run marks the last
// result of an input item.
// An accepted byte is parsed in the same cycle and its results are written into
// the result queue, which issues them in order. One byte is accepted per cycle
// while the queue has room; a final byte that also carries payload yields two
// results, payload item first. Results wait in a four-entry queue, and in_ready
// is high while it has room for two items, so a stalled receiver holds the
// input back once three results wait. Reset clears the parser state and the
// queue and sets magic_value to 0 and the payload length limit to 65535. The
// configuration port writes register 0 (magic_value) or 1 (the payload length
// limit); the user must write only while the block is idle (not enforced).
module packet_deframer_crc32_check_unit
    import pdf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [15:0] cfg_wdata
);

    push_t push;
    logic  room;
    logic  take;

    assign in_ready = room;
    assign take     = in_valid && room;

    pdf_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .take      (take),
        .in_data   (in_data),
        .push      (push)
    );

    pdf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .room      (room),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// File: sim/packet_deframer_crc32_check_unit_test.sv
// Testbench for the packet deframer: directed and random buffers against a byte-level model.
module packet_deframer_crc32_check_unit_test;
    import pdf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_ready;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [15:0] cfg_wdata;

    packet_deframer_crc32_check_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    logic [15:0] magic_cfg;
    logic [15:0] max_len_cfg;

    count_t      rx_count;
    logic [31:0] rx_crc;
    logic [15:0] rx_magic;
    logic [7:0]  rx_type;
    logic [31:0] rx_conn;
    logic [31:0] rx_seq;
    logic [31:0] rx_ack;
    logic [15:0] rx_len;
    logic [31:0] rx_sum;
    logic [7:0]  rx_pad;

    out_item_t   parsed_results[$];
    logic [7:0]  frame_buf[$];

    int send_idle_pct   = 0;
    int recv_idle_pct   = 0;
    int hold_off_cycles = 0;
    int mismatches      = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #4ms;
        $display("FAIL");
        $finish;
    end

    function automatic logic [31:0] crc_update(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'h0, b};
        for (int i = 0; i < 8; i++)
        begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    task automatic clear_parse_state();
        rx_count = '0;
        rx_crc   = CRC_ONES;
        rx_magic = '0;
        rx_type  = '0;
        rx_conn  = '0;
        rx_seq   = '0;
        rx_ack   = '0;
        rx_len   = '0;
        rx_sum   = '0;
        rx_pad   = '0;
    endtask

    task automatic parse_byte(input logic [7:0] b, input logic is_last);
        out_item_t r;
        count_t    p;
        count_t    frame_end;
        p = rx_count;
        frame_end = HDR_LEN + count_t'(rx_len);
        if (p < HDR_LEN)
        begin
            if (p < OFS_TYPE)
                rx_magic = {rx_magic[7:0], b};
            else if (p == OFS_TYPE)
                rx_type = b;
            else if (p < OFS_SEQ)
                rx_conn = {rx_conn[23:0], b};
            else if (p < OFS_ACK)
                rx_seq = {rx_seq[23:0], b};
            else if (p < OFS_LEN)
                rx_ack = {rx_ack[23:0], b};
            else if (p < OFS_SUM)
                rx_len = {rx_len[7:0], b};
            else if (p < OFS_PAD)
                rx_sum = {rx_sum[23:0], b};
            else
                rx_pad = b;
            rx_crc = crc_update(rx_crc, (p >= OFS_SUM && p < OFS_PAD) ? 8'h00 : b);
        end
        else if (p < frame_end)
        begin
            rx_crc = crc_update(rx_crc, b);
            r = '0;
            r.kind = KIND_PAYLOAD;
            r.payload_byte = b;
            r.end_of_run = !is_last;
            parsed_results.push_back(r);
        end
        if (rx_count != COUNT_MAX)
            rx_count++;
        if (is_last)
        begin
            frame_end = HDR_LEN + count_t'(rx_len);
            r = '0;
            r.kind = KIND_VERDICT;
            if (rx_count < HDR_LEN)
                r.status = ST_SHORT;
            else if (rx_magic != magic_cfg)
                r.status = ST_BAD_MAGIC;
            else if (rx_len > max_len_cfg)
                r.status = ST_TOO_LONG;
            else if (rx_count < frame_end)
                r.status = ST_TRUNCATED;
            else if ((rx_crc ^ CRC_ONES) != rx_sum)
                r.status = ST_CRC_BAD;
            else
                r.status = ST_OK;
            r.pkt_type    = rx_type;
            r.conn_id     = rx_conn;
            r.seq_num     = rx_seq;
            r.ack_num     = rx_ack;
            r.payload_len = rx_len;
            r.rx_checksum = rx_sum;
            r.pad_byte    = rx_pad;
            r.end_of_run  = 1'b1;
            parsed_results.push_back(r);
            clear_parse_state();
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic is_last);
        if (send_idle_pct > 0)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, last: is_last};
        do
            @(posedge clk);
        while (!in_ready);
        parse_byte(b, is_last);
    endtask

    task automatic send_buffer();
        foreach (frame_buf[i])
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        while (parsed_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == CFG_MAGIC)
            magic_cfg = data;
        else
            max_len_cfg = data;
    endtask

    task automatic seal_frame();
        logic [31:0] crc;
        crc = CRC_ONES;
        foreach (frame_buf[i])
            crc = crc_update(crc, (i >= 17 && i <= 20) ? 8'h00 : frame_buf[i]);
        crc = crc ^ CRC_ONES;
        frame_buf[17] = crc[31:24];
        frame_buf[18] = crc[23:16];
        frame_buf[19] = crc[15:8];
        frame_buf[20] = crc[7:0];
    endtask

    task automatic build_frame(input logic [15:0] magic, input logic [15:0] len, input int n_pay);
        frame_buf.delete();
        frame_buf.push_back(magic[15:8]);
        frame_buf.push_back(magic[7:0]);
        repeat (13) frame_buf.push_back(8'($urandom));
        frame_buf.push_back(len[15:8]);
        frame_buf.push_back(len[7:0]);
        repeat (4) frame_buf.push_back(8'h00);
        frame_buf.push_back(8'($urandom));
        repeat (n_pay) frame_buf.push_back(8'($urandom));
        seal_frame();
    endtask

    task automatic fill_frame(input logic [7:0] v);
        foreach (frame_buf[i])
        begin
            if ((i >= 2 && i <= 14) || i >= 21)
                frame_buf[i] = v;
        end
        seal_frame();
    endtask

    task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_cycles > 0)
            begin
                out_ready <= 1'b0;
                hold_off_cycles--;
            end
            else
                out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    initial
    begin : match_results
        out_item_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (parsed_results.size() == 0)
                begin
                    $display("%0t: unexpected item, expected none, got %h", $time, out_data);
                    mismatches++;
                end
                else
                begin
                    want = parsed_results.pop_front();
                    check_field("kind", 32'(want.kind), 32'(out_data.kind));
                    check_field("payload_byte", 32'(want.payload_byte),
                                32'(out_data.payload_byte));
                    check_field("status", 32'(want.status), 32'(out_data.status));
                    check_field("pkt_type", 32'(want.pkt_type), 32'(out_data.pkt_type));
                    check_field("conn_id", want.conn_id, out_data.conn_id);
                    check_field("seq_num", want.seq_num, out_data.seq_num);
                    check_field("ack_num", want.ack_num, out_data.ack_num);
                    check_field("payload_len", 32'(want.payload_len),
                                32'(out_data.payload_len));
                    check_field("rx_checksum", want.rx_checksum, out_data.rx_checksum);
                    check_field("pad_byte", 32'(want.pad_byte), 32'(out_data.pad_byte));
                    check_field("end_of_run", 32'(want.end_of_run), 32'(out_data.end_of_run));
                end
            end
        end
    end

    task automatic test_header_extremes();
        send_idle_pct = 34;
        recv_idle_pct = 61;
        build_frame(16'h0000, 16'd0, 0);
        fill_frame(8'h00);
        send_buffer();
        build_frame(16'h0000, 16'd1, 1);
        fill_frame(8'hFF);
        send_buffer();
        wait_idle();
        write_reg(CFG_MAGIC, 16'hFFFF);
        build_frame(16'hFFFF, 16'd3, 3);
        fill_frame(8'hFF);
        send_buffer();
    endtask

    task automatic test_short_buffers();
        int cuts[4] = '{1, 2, 17, 21};
        foreach (cuts[k])
        begin
            build_frame(16'hFFFF, 16'd0, 0);
            frame_buf = frame_buf[0:cuts[k]-1];
            send_buffer();
        end
    endtask

    task automatic test_verdict_order();
        wait_idle();
        write_reg(CFG_MAGIC, 16'hA55A);
        write_reg(CFG_MAX_LEN, 16'd8);
        build_frame(16'h5AA5, 16'd9, 9);
        send_buffer();
        build_frame(16'hA55A, 16'd9, 2);
        send_buffer();
        build_frame(16'hA55A, 16'd8, 3);
        send_buffer();
        build_frame(16'hA55A, 16'd5, 5);
        frame_buf[23] ^= 8'h10;
        send_buffer();
        build_frame(16'hA55A, 16'd4, 4);
        repeat (3) frame_buf.push_back(8'($urandom));
        send_buffer();
        build_frame(16'hA55A, 16'hFFFF, 4);
        send_buffer();
        wait_idle();
        write_reg(CFG_MAX_LEN, 16'd0);
        build_frame(16'hA55A, 16'd0, 0);
        send_buffer();
        build_frame(16'hA55A, 16'd1, 1);
        send_buffer();
        wait_idle();
        write_reg(CFG_MAX_LEN, 16'hFFFF);
        build_frame(16'hA55A, 16'hFFFF, 4);
        send_buffer();
    endtask

    task automatic test_backpressure();
        wait_idle();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_off_cycles = 200;
        build_frame(16'hA55A, 16'd40, 40);
        send_buffer();
        build_frame(16'hA55A, 16'd12, 12);
        send_buffer();
    endtask

    task automatic test_random(input int sender_pct, input int receiver_pct,
                               input logic [15:0] magic, input logic [15:0] max_len,
                               input int n_items);
        int          sent;
        int          pick;
        int          idx;
        logic [15:0] len;
        wait_idle();
        send_idle_pct = sender_pct;
        recv_idle_pct = receiver_pct;
        write_reg(CFG_MAGIC, magic);
        write_reg(CFG_MAX_LEN, max_len);
        sent = 0;
        while (sent < n_items)
        begin
            pick = $urandom_range(99);
            len = ($urandom_range(19) == 0) ? 16'($urandom_range(40)) : 16'($urandom_range(12));
            if (pick >= 89 && pick < 94 && max_len < 16'd64)
            begin
                len = max_len + 16'($urandom_range(1, 5));
                build_frame(magic, len, $urandom_range(0, 6));
            end
            else if (pick >= 94)
            begin
                frame_buf.delete();
                repeat ($urandom_range(1, 30)) frame_buf.push_back(8'($urandom));
                if (frame_buf.size() >= 2 && $urandom_range(1) == 1)
                begin
                    frame_buf[0] = magic[15:8];
                    frame_buf[1] = magic[7:0];
                end
            end
            else
            begin
                if (pick >= 83 && pick < 89)
                    build_frame(magic ^ 16'($urandom_range(1, 65535)), len, int'(len));
                else
                    build_frame(magic, len, int'(len));
                if (pick >= 60 && pick < 68)
                begin
                    idx = $urandom_range(2, frame_buf.size() - 1);
                    if (idx == 15 || idx == 16)
                        idx = 2;
                    frame_buf[idx] ^= 8'(1 << $urandom_range(7));
                end
                else if (pick >= 68 && pick < 76)
                    frame_buf = frame_buf[0:$urandom_range(1, frame_buf.size() - 1) - 1];
                else if (pick >= 76 && pick < 83)
                    repeat ($urandom_range(1, 6)) frame_buf.push_back(8'($urandom));
            end
            sent += frame_buf.size();
            send_buffer();
        end
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_MAGIC;
        cfg_wdata = '0;
        magic_cfg   = 16'h0000;
        max_len_cfg = 16'hFFFF;
        clear_parse_state();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_header_extremes();
        test_short_buffers();
        test_verdict_order();
        test_random(34, 61, 16'($urandom), 16'hFFFF, 80);
        test_random(61, 34, 16'hFFFF, 16'd16, 80);
        test_random(0, 0, 16'($urandom), 16'($urandom_range(8, 40)), 80);
        test_backpressure();
        wait_idle();

        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

// File: sim.f
rtl/core/pdf_pkg.sv
rtl/core/pdf_parse.sv
rtl/core/pdf_queue.sv
rtl/core/packet_deframer_crc32_check_unit.sv
sim/packet_deframer_crc32_check_unit_test.sv
